// ===== design/fbsf_pkg.sv =====
// shared types and constants for the framebuffer shape fill block
`default_nettype none

package fbsf_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration register width and index codes
  localparam int CFG_W = 9;
  localparam logic REG_ACTIVE_WIDTH  = 1'b0;
  localparam logic REG_ACTIVE_HEIGHT = 1'b1;

  // signed bound and distance widths
  localparam int BW  = 18;
  localparam int SQW = 31;
  localparam int R2W = 30;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_RECT   = 2'd1,
    REQ_CIRCLE = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        size_a;
    logic [14:0]        size_b;
    logic [31:0]        fill_color;
  } req_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        out_of_range;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic rd_en;
    logic out_load;
  } fbsf_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic out_free;
  } fbsf_sts_t;

endpackage

`default_nettype wire

// ===== design/fbsf_ctrl.sv =====
// command sequencer for the framebuffer shape fill block
`default_nettype none

module fbsf_ctrl
  import fbsf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] req_type_i,
  output logic            in_ready_o,
  input  wire fbsf_sts_t  sts_i,
  output fbsf_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SETUP  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_RDMEM  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (req_type_i == REQ_READ) ? ST_RDMEM : ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          if (sts_i.last) state_d = ST_DRAIN;
        end
      end
      // last pixel of the scan is written here
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      ST_RDMEM: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ===== design/fbsf_dp.sv =====
// datapath: config registers, scan counters, circle test, frame store, output register
`default_nettype none

module fbsf_dp
  import fbsf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire req_t             in_data_i,
  input  wire logic             cfg_valid_i,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output rsp_t                  out_data_o,
  input  wire fbsf_cmd_t        cmd_i,
  output fbsf_sts_t             sts_o
);

  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [CFG_W-1:0] w_eff, h_eff;
  req_t             req_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_W'(256);
      cfg_h_q <= CFG_W'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ACTIVE_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_ACTIVE_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w_eff = (32'(cfg_w_q) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : cfg_w_q;
  assign h_eff = (32'(cfg_h_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : cfg_h_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
  end

  // bounding box before clipping
  logic signed [BW-1:0] cx, cy, span_x, span_y;
  logic signed [BW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic signed [BW-1:0] w_s, h_s;
  logic                 is_clear, is_circ, empty_x, empty_y;
  logic [XW-1:0]        x0, x1;
  logic [YW-1:0]        y0, y1;

  assign is_clear = (req_q.req_type == REQ_CLEAR);
  assign is_circ  = (req_q.req_type == REQ_CIRCLE);
  assign cx       = BW'(req_q.pos_x);
  assign cy       = BW'(req_q.pos_y);
  assign w_s      = $signed(BW'(w_eff));
  assign h_s      = $signed(BW'(h_eff));

  always_comb begin
    if (is_circ) begin
      span_x = $signed(BW'(req_q.size_a));
      span_y = $signed(BW'(req_q.size_a));
    end else begin
      span_x = $signed(BW'(req_q.size_a >> 1));
      span_y = $signed(BW'(req_q.size_b >> 1));
    end
    if (is_clear) begin
      lo_x = '0;
      lo_y = '0;
      hi_x = {1'b0, {(BW-1){1'b1}}};
      hi_y = {1'b0, {(BW-1){1'b1}}};
    end else begin
      lo_x = cx - span_x;
      hi_x = cx + span_x;
      lo_y = cy - span_y;
      hi_y = cy + span_y;
    end
  end

  assign empty_x = (w_eff == '0) || (hi_x < 0) || (lo_x >= w_s);
  assign empty_y = (h_eff == '0) || (hi_y < 0) || (lo_y >= h_s);
  assign x0 = (lo_x < 0) ? '0 : lo_x[XW-1:0];
  assign x1 = (hi_x >= w_s) ? XW'(w_eff - 1'b1) : hi_x[XW-1:0];
  assign y0 = (lo_y < 0) ? '0 : lo_y[YW-1:0];
  assign y1 = (hi_y >= h_s) ? YW'(h_eff - 1'b1) : hi_y[YW-1:0];

  // scan state
  logic [XW-1:0]  x_q, x0_q, x1_q;
  logic [YW-1:0]  y_q, y1_q;
  logic           empty_q, circ_q;
  logic [R2W-1:0] r2_q;
  logic           at_row_end;

  assign at_row_end = (x_q == x1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      x0_q    <= x0;
      x1_q    <= x1;
      y1_q    <= y1;
      x_q     <= x0;
      y_q     <= y0;
      empty_q <= empty_x | empty_y;
      circ_q  <= is_circ;
      r2_q    <= R2W'(req_q.size_a * req_q.size_a);
    end else if (cmd_i.step) begin
      if (at_row_end) begin
        x_q <= x0_q;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

  // pipeline stage 1: squared distances
  logic signed [BW-1:0]   dx, dy;
  logic signed [2*BW-1:0] dx_sq, dy_sq;
  logic                   p1_valid_q;
  logic [AW-1:0]          p1_addr_q;
  logic [SQW-1:0]         p1_dx2_q, p1_dy2_q;

  assign dx    = $signed(BW'(x_q)) - cx;
  assign dy    = $signed(BW'(y_q)) - cy;
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else begin
      p1_valid_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      p1_addr_q <= AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
      p1_dx2_q  <= dx_sq[SQW-1:0];
      p1_dy2_q  <= dy_sq[SQW-1:0];
    end
  end

  // stage 2: radius test and frame store write
  logic [SQW:0] dist2;
  logic         wr_en;

  assign dist2 = {1'b0, p1_dx2_q} + {1'b0, p1_dy2_q};
  assign wr_en = p1_valid_q && (!circ_q || (dist2 <= (SQW+1)'(r2_q)));

  // read path
  logic          oor;
  logic [AW-1:0] rd_addr;
  logic          oor_q;
  logic [31:0]   rd_data_q;
  logic [31:0]   mem_q [DEPTH];

  assign oor = (req_q.pos_x < 0) || (req_q.pos_y < 0) ||
               (cx >= w_s) || (cy >= h_s);
  assign rd_addr = AW'(32'(req_q.pos_y[YW-1:0]) * MAX_WIDTH + 32'(req_q.pos_x[XW-1:0]));

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[p1_addr_q] <= req_q.fill_color;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      oor_q     <= oor;
    end
  end

  // output register
  logic out_valid_q;
  rsp_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.pixel_value  <= oor_q ? '0 : rd_data_q;
      out_data_q.out_of_range <= oor_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign sts_o.empty     = empty_q;
  assign sts_o.last      = at_row_end && (y_q == y1_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ===== design/framebuffer_shape_fill_top.sv =====
// top level of the framebuffer shape fill block
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one command item:
//   clear, fill rectangle, fill circle or read pixel. cfg channel writes
//   active_width (index 0) and active_height (index 1); always ready.
//   out channel carries one item for every read: pixel word and an
//   out-of-range flag. Fills and clears give no out item.
// Timing:
//   a fill scans its clipped bounding box one pixel per cycle through a
//   two-stage distance/write pipe. A shape that misses the area is not
//   scanned. A read registers the frame store word, then loads it into
//   the out register once that register is free.
//   One command is worked on at a time; in_ready_o is high only when idle.
// Reset: config returns to 256x256; frame store contents are undefined
//   until written. The pending out item is dropped.
// Stall: the out register holds its item while out_ready_i is low; new
//   commands are still taken, and a later read waits until it is free.
`default_nettype none

module framebuffer_shape_fill_top
  import fbsf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire req_t             in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rsp_t                  out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  fbsf_cmd_t cmd;
  fbsf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fbsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (in_data_i.req_type),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbsf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
